@@ design/assert_macros.svh @@
// Assertion macros shared by the RTL files.
// Each macro checks a property on the rising edge of the given clock and is
// switched off while the given reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_SAME(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ design/udr_pkg.sv @@
`default_nettype none

package udr_pkg;

  // Byte counts and code point limits.
  localparam int unsigned BUF_DEPTH = 4;
  localparam int unsigned CP_WIDTH  = 21;

  localparam logic [CP_WIDTH-1:0] REPLACEMENT_CP = 21'h00FFFD;
  localparam logic [CP_WIDTH-1:0] MIN_CP_2BYTE   = 21'h000080;
  localparam logic [CP_WIDTH-1:0] MIN_CP_3BYTE   = 21'h000800;
  localparam logic [CP_WIDTH-1:0] MIN_CP_4BYTE   = 21'h010000;
  localparam logic [CP_WIDTH-1:0] MAX_CP         = 21'h10FFFF;

  // Controller states.
  typedef enum logic {
    ST_IDLE,
    ST_WORK
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // append the accepted word to the byte buffer
    logic step;   // emit one result and consume its bytes
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic stop;      // nothing more to emit for the current word
    logic last;      // the result on offer is the last one for this word
    logic out_free;  // the output register can take a result this cycle
  } status_t;

endpackage

`default_nettype wire

@@ design/udr_ctrl.sv @@
`default_nettype none

module udr_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire udr_pkg::status_t sts,
  output logic                  in_stall,
  output udr_pkg::cmd_t         cmd
);
  import udr_pkg::*;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state: one word is taken in idle, then results are issued until done.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_WORK;
        end
      end
      ST_WORK: begin
        if (sts.stop) begin
          state_next = ST_IDLE;
        end else if (sts.out_free && sts.last) begin
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  // Outputs: accept only in idle and out of reset; in work, step whenever there
  // is a result to emit and the output register has room.
  always_comb begin
    in_stall = 1'b1;
    cmd      = '0;
    unique case (state)
      ST_IDLE: begin
        in_stall = rst;
        cmd.load = in_valid && !rst;
      end
      ST_WORK: begin
        cmd.step = !sts.stop && sts.out_free;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ design/udr_datapath.sv @@
`default_nettype none
`include "assert_macros.svh"

module udr_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [7:0]                    data_byte,
  input  wire logic                          final_byte,
  input  wire udr_pkg::cmd_t                 cmd,
  input  wire logic                          out_stall,
  output udr_pkg::status_t                   sts,
  output logic                               out_valid,
  output logic [udr_pkg::CP_WIDTH-1:0]       code_point,
  output logic                               replaced,
  output logic                               run_last,
  output logic                               stream_last
);
  import udr_pkg::*;

  typedef struct packed {
    logic                stop;
    logic                bad;
    logic [CP_WIDTH-1:0] cp;
    logic [2:0]          used;
  } dec_t;

  // Sequence length from the lead byte; zero marks a bad lead.
  function automatic logic [2:0] seq_len(input logic [7:0] b);
    logic [2:0] len;
    priority if (b[7] == 1'b0)      len = 3'd1;
    else if (b[7:5] == 3'b110)      len = 3'd2;
    else if (b[7:4] == 4'b1110)     len = 3'd3;
    else if (b[7:3] == 5'b11110)    len = 3'd4;
    else                            len = 3'd0;
    return len;
  endfunction

  // Decode the sequence at the front of the buffer.
  function automatic dec_t decode(input logic [BUF_DEPTH-1:0][7:0] b,
                                  input logic [2:0] n, input logic fin);
    dec_t                d;
    logic [2:0]          len;
    logic                bad;
    logic [CP_WIDTH-1:0] cp;
    d   = '0;
    len = seq_len(b[0]);
    bad = 1'b0;
    cp  = '0;
    if (n == 3'd0) begin
      d.stop = 1'b1;
    end else if (len == 3'd0) begin
      bad = 1'b1;
    end else if (len == 3'd1) begin
      cp = {13'd0, b[0]};
    end else begin
      for (int i = 1; i < BUF_DEPTH; i++) begin
        if (3'(i) < len && 3'(i) < n && b[i][7:6] != 2'b10) begin
          bad = 1'b1;
        end
      end
      if (!bad && n < len) begin
        if (!fin) begin
          d.stop = 1'b1;
        end else begin
          bad = 1'b1;
        end
      end
      if (!bad && !d.stop) begin
        case (len)
          3'd2: begin
            cp  = {10'd0, b[0][4:0], b[1][5:0]};
            bad = cp < MIN_CP_2BYTE;
          end
          3'd3: begin
            cp  = {5'd0, b[0][3:0], b[1][5:0], b[2][5:0]};
            bad = cp < MIN_CP_3BYTE;
          end
          default: begin
            cp  = {b[0][2:0], b[1][5:0], b[2][5:0], b[3][5:0]};
            bad = (cp < MIN_CP_4BYTE) || (cp > MAX_CP);
          end
        endcase
      end
    end
    d.bad  = bad;
    d.cp   = bad ? REPLACEMENT_CP : cp;
    d.used = (bad || len == 3'd1) ? 3'd1 : len;
    return d;
  endfunction

  logic [BUF_DEPTH-1:0][7:0] buf_bytes;
  logic [2:0]                buf_count;
  logic                      fin;

  dec_t                      dec_cur;
  dec_t                      dec_rem;
  logic [BUF_DEPTH-1:0][7:0] rem_bytes;
  logic [2:0]                rem_count;

  // Decode the front sequence, then look ahead at what remains after it.
  always_comb begin
    dec_cur   = decode(buf_bytes, buf_count, fin);
    rem_bytes = buf_bytes >> {dec_cur.used, 3'b000};
    rem_count = buf_count - dec_cur.used;
    dec_rem   = decode(rem_bytes, rem_count, fin);
  end

  assign sts.stop     = dec_cur.stop;
  assign sts.last     = (rem_count == 3'd0) || dec_rem.stop;
  assign sts.out_free = !out_valid || !out_stall;

  // Byte buffer: held bytes sit at the front, a new word is appended.
  always_ff @(posedge clk) begin
    if (rst) begin
      buf_count <= 3'd0;
    end else if (cmd.load) begin
      buf_count <= buf_count + 3'd1;
    end else if (cmd.step) begin
      buf_count <= rem_count;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      buf_bytes[buf_count[1:0]] <= data_byte;
      fin                       <= final_byte;
    end else if (cmd.step) begin
      buf_bytes <= rem_bytes;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.step) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      code_point  <= dec_cur.cp;
      replaced    <= dec_cur.bad;
      run_last    <= sts.last;
      stream_last <= sts.last && fin;
    end
  end

  // A result is issued only when there is one and the output has room.
  `ASSERT_SAME(a_step_has_result, clk, rst, cmd.step, !sts.stop && sts.out_free)
  // A new word always finds a free slot in the buffer.
  `ASSERT_SAME(a_load_room, clk, rst, cmd.load, buf_count <= 3'd3)
  // The last result of a final word leaves nothing held.
  `ASSERT_NEXT(a_flush_at_end, clk, rst, cmd.step && sts.last && fin, buf_count == 3'd0)
  // When a result is issued, the buffer holds one to four bytes.
  `ASSERT_SAME(a_count_range, clk, rst, cmd.step, buf_count <= 3'd4 && buf_count != 3'd0)

endmodule

`default_nettype wire

@@ design/utf8_decode_with_replacement_unit.sv @@
// UTF-8 decoder with replacement character.
// Input channel: one stream byte per word (data_byte) with final_byte set on
// the last byte of a stream; in_valid/in_stall handshake.
// Output channel: one decoded code point per word (code_point), replaced set
// for U+FFFD substitutes, run_last on the last result caused by an input byte
// and stream_last on the last result of a stream; out_valid/out_stall handshake.
// An input byte gives zero to four results. The byte is accepted in idle,
// then the controller issues one result per cycle from the byte buffer while
// the output register has room. A byte is registered in the byte buffer, and
// its first result then in the output register. The datapath makes a single
// decoder step per issued result, and the controller takes a new byte only
// once the last result of the previous byte is issued.
// When the receiver stalls, the output register holds its word and decoding
// pauses; a new byte can still be accepted once the previous one is issued.
// Reset clears the held byte count, the controller state and out_valid, and
// in_stall stays high while reset is asserted.
`default_nettype none

module utf8_decode_with_replacement_unit (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [7:0]              data_byte,
  input  wire logic                    final_byte,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic [udr_pkg::CP_WIDTH-1:0] code_point,
  output logic                         replaced,
  output logic                         run_last,
  output logic                         stream_last
);
  import udr_pkg::*;

  cmd_t    cmd;
  status_t sts;

  // Controller.
  udr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .sts      (sts),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  // Datapath with byte buffer, decoder and output register.
  udr_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .data_byte   (data_byte),
    .final_byte  (final_byte),
    .cmd         (cmd),
    .out_stall   (out_stall),
    .sts         (sts),
    .out_valid   (out_valid),
    .code_point  (code_point),
    .replaced    (replaced),
    .run_last    (run_last),
    .stream_last (stream_last)
  );

endmodule

`default_nettype wire
